// ----- src/tli_pkg.sv -----
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants for the table interpolator
// command and status bundles, codes, state encoding and fixed widths
// ----------------------------------------------------------------------------
package tli_pkg;

   // default sizes handed to the top level parameters
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_BITS_DEF    = 16;
   localparam int VALUE_BITS_DEF  = 32;

   // weight is a q0.16 fraction, one extra bit holds unity
   localparam int WEIGHT_BITS = 16;
   localparam int WEIGHT_W    = WEIGHT_BITS + 1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(1) << WEIGHT_BITS;
   localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = WEIGHT_W'(1) << (WEIGHT_BITS - 1);

   // register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   // item commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // range status codes
   localparam logic [1:0] RANGE_INSIDE = 2'd0;
   localparam logic [1:0] RANGE_BELOW  = 2'd1;
   localparam logic [1:0] RANGE_ABOVE  = 2'd2;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_DIV,
      ST_VAL_HI,
      ST_VAL_LO,
      ST_MAC_GO,
      ST_MAC,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_wr;
      logic query_start;
      logic rd_last;
      logic classify;
      logic scan;
      logic val_rd_hi;
      logic val_rd_lo;
      logic mac_start;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_range;
      logic found;
      logic div_done;
      logic mac_done;
      logic out_free;
   } dp_status_type;

endpackage

// ----- src/tli_div.sv -----
// ----------------------------------------------------------------------------
// tli_div: iterative restoring divider for the upper weight
// one quotient bit per cycle, numerator known to be below the divisor
// ----------------------------------------------------------------------------
module tli_div
   import tli_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [KEY_BITS-1:0]    num,
   input  logic [KEY_BITS-1:0]    den,
   output logic [WEIGHT_BITS-1:0] quo,
   output logic                   done
);

   localparam int CNT_W = $clog2(WEIGHT_BITS);
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(WEIGHT_BITS - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [KEY_BITS-1:0]    rem_ff, rem_in;
   logic [KEY_BITS-1:0]    den_ff, den_in;
   logic [WEIGHT_BITS-1:0] quo_ff, quo_in;
   logic [KEY_BITS:0]      shifted;
   logic [KEY_BITS:0]      trial;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!trial[KEY_BITS]) begin
            rem_in = trial[KEY_BITS-1:0];
            quo_in = {quo_ff[WEIGHT_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[KEY_BITS-1:0];
            quo_in = {quo_ff[WEIGHT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands and partial quotient
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// ----- src/tli_mac.sv -----
// ----------------------------------------------------------------------------
// tli_mac: shift-add blend of the two bracketing values
// forms vh*wh + vl*(one-wh) one weight bit per cycle, then drops 16 bits
// ----------------------------------------------------------------------------
module tli_mac
   import tli_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] vh,
   input  logic [VALUE_BITS-1:0] vl,
   input  logic [WEIGHT_W-1:0]   wh,
   output logic [VALUE_BITS-1:0] result,
   output logic                  done
);

   localparam int ACC_W = VALUE_BITS + WEIGHT_W;
   localparam int CNT_W = $clog2(WEIGHT_W);
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(WEIGHT_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]    mh_ff, mh_in;
   logic [ACC_W-1:0]    ml_ff, ml_in;
   logic [WEIGHT_W-1:0] wh_ff, wh_in;
   logic [WEIGHT_W-1:0] wl_ff, wl_in;
   logic [ACC_W-1:0]    add_h;
   logic [ACC_W-1:0]    add_l;

   // one partial product pair per cycle
   always_comb begin
      add_h   = wh_ff[0] ? mh_ff : '0;
      add_l   = wl_ff[0] ? ml_ff : '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mh_in   = mh_ff;
      ml_in   = ml_ff;
      wh_in   = wh_ff;
      wl_in   = wl_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         mh_in   = ACC_W'(vh);
         ml_in   = ACC_W'(vl);
         wh_in   = wh;
         wl_in   = WEIGHT_ONE - wh;
      end else if (busy_ff) begin
         acc_in = acc_ff + add_h + add_l;
         mh_in  = {mh_ff[ACC_W-2:0], 1'b0};
         ml_in  = {ml_ff[ACC_W-2:0], 1'b0};
         wh_in  = {1'b0, wh_ff[WEIGHT_W-1:1]};
         wl_in  = {1'b0, wl_ff[WEIGHT_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // accumulator and shifting operands
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mh_ff  <= mh_in;
      ml_ff  <= ml_in;
      wh_ff  <= wh_in;
      wl_ff  <= wl_in;
   end

   // truncate the q0.16 weight fraction
   assign result = acc_ff[WEIGHT_BITS +: VALUE_BITS];
   assign done   = done_ff;

endmodule

// ----- src/tli_datapath.sv -----
// ----------------------------------------------------------------------------
// tli_datapath: table store, key scan, weight and blend
// holds the key and value memories, the bracket registers and the result beat
// ----------------------------------------------------------------------------
module tli_datapath
   import tli_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF,
   parameter int IDX_W       = $clog2(TABLE_DEPTH),
   parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [CNT_W-1:0]      entries_in_use,
   input  logic [IDX_W-1:0]      entry_index,
   input  logic [KEY_BITS-1:0]   entry_key,
   input  logic [VALUE_BITS-1:0] entry_value,
   input  logic [KEY_BITS-1:0]   query_key,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_interpolated_value,
   output logic [KEY_BITS-1:0]   rsp_clamped_key,
   output logic [IDX_W-1:0]      rsp_low_index,
   output logic [IDX_W-1:0]      rsp_high_index,
   output logic [WEIGHT_W-1:0]   rsp_high_weight,
   output logic [1:0]            rsp_range_status
);

   // table memories
   logic [KEY_BITS-1:0]   keys_mem   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] values_mem [TABLE_DEPTH];

   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic                  key_rd_en;
   logic [IDX_W-1:0]      key_addr;
   logic                  val_rd_en;
   logic [IDX_W-1:0]      val_addr;
   logic                  load_ok;

   // query working registers
   logic [KEY_BITS-1:0]   q_ff, kmin_ff, prev_ff, key_out_ff;
   logic [IDX_W-1:0]      scan_ff, lo_ff, hi_ff;
   logic [WEIGHT_W-1:0]   wh_ff;
   logic [1:0]            range_ff;
   logic [VALUE_BITS-1:0] vh_ff;

   // result beat
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] out_value_ff;
   logic [KEY_BITS-1:0]   out_key_ff;
   logic [IDX_W-1:0]      out_lo_ff, out_hi_ff;
   logic [WEIGHT_W-1:0]   out_wh_ff;
   logic [1:0]            out_range_ff;

   logic [CNT_W-1:0]      active_cnt;
   logic [CNT_W-1:0]      last_cnt;
   logic [IDX_W-1:0]      last_idx;
   logic                  below, above, found;

   logic [WEIGHT_BITS-1:0] div_quo;
   logic                   div_done;
   logic [VALUE_BITS-1:0]  mac_result;
   logic                   mac_done;

   // entries searched, held within two and the depth
   always_comb begin
      priority if (entries_in_use < CNT_W'(2)) begin
         active_cnt = CNT_W'(2);
      end else if (entries_in_use > CNT_W'(TABLE_DEPTH)) begin
         active_cnt = CNT_W'(TABLE_DEPTH);
      end else begin
         active_cnt = entries_in_use;
      end
      last_cnt = active_cnt - CNT_W'(1);
      last_idx = last_cnt[IDX_W-1:0];
   end

   // range compares and scan hit
   assign below   = (q_ff <= kmin_ff);
   assign above   = !below && (q_ff >= key_rd_ff);
   assign found   = (key_rd_ff > q_ff);
   assign load_ok = ({1'b0, entry_index} < (IDX_W + 1)'(TABLE_DEPTH));

   // key read address
   always_comb begin
      key_rd_en = 1'b0;
      key_addr  = '0;
      priority if (cmd.query_start) begin
         key_rd_en = 1'b1;
         key_addr  = '0;
      end else if (cmd.rd_last) begin
         key_rd_en = 1'b1;
         key_addr  = last_idx;
      end else if (cmd.classify) begin
         key_rd_en = 1'b1;
         key_addr  = IDX_W'(1);
      end else if (cmd.scan && !found) begin
         key_rd_en = 1'b1;
         key_addr  = scan_ff + IDX_W'(1);
      end else begin
         key_rd_en = 1'b0;
      end
   end

   // value read address
   assign val_rd_en = cmd.val_rd_hi || cmd.val_rd_lo;
   assign val_addr  = cmd.val_rd_hi ? hi_ff : lo_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_ok) begin
         keys_mem[entry_index]   <= entry_key;
         values_mem[entry_index] <= entry_value;
      end
      if (key_rd_en) begin
         key_rd_ff <= keys_mem[key_addr];
      end
      if (val_rd_en) begin
         val_rd_ff <= values_mem[val_addr];
      end
   end

   // bracket, weight and status registers
   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         q_ff <= query_key;
      end
      if (cmd.rd_last) begin
         kmin_ff <= key_rd_ff;
      end
      if (cmd.classify) begin
         priority if (below) begin
            lo_ff      <= '0;
            hi_ff      <= '0;
            wh_ff      <= WEIGHT_HALF;
            key_out_ff <= kmin_ff;
            range_ff   <= RANGE_BELOW;
         end else if (above) begin
            lo_ff      <= last_idx;
            hi_ff      <= last_idx;
            wh_ff      <= WEIGHT_HALF;
            key_out_ff <= key_rd_ff;
            range_ff   <= RANGE_ABOVE;
         end else begin
            key_out_ff <= q_ff;
            range_ff   <= RANGE_INSIDE;
            prev_ff    <= kmin_ff;
            scan_ff    <= IDX_W'(1);
         end
      end
      if (cmd.scan) begin
         if (found) begin
            hi_ff <= scan_ff;
            lo_ff <= scan_ff - IDX_W'(1);
         end else begin
            prev_ff <= key_rd_ff;
            scan_ff <= scan_ff + IDX_W'(1);
         end
      end
      if (div_done) begin
         wh_ff <= {1'b0, div_quo};
      end
      if (cmd.val_rd_lo) begin
         vh_ff <= val_rd_ff;
      end
   end

   // weight of the upper entry
   tli_div #(
      .KEY_BITS (KEY_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.scan && found),
      .num   (q_ff - prev_ff),
      .den   (key_rd_ff - prev_ff),
      .quo   (div_quo),
      .done  (div_done)
   );

   // blend of the bracketing values
   tli_mac #(
      .VALUE_BITS (VALUE_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mac_start),
      .vh     (vh_ff),
      .vl     (val_rd_ff),
      .wh     (wh_ff),
      .result (mac_result),
      .done   (mac_done)
   );

   // result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff <= mac_result;
         out_key_ff   <= key_out_ff;
         out_lo_ff    <= lo_ff;
         out_hi_ff    <= hi_ff;
         out_wh_ff    <= wh_ff;
         out_range_ff <= range_ff;
      end
   end

   // status to the controller
   always_comb begin
      status.in_range = !below && !above;
      status.found    = found;
      status.div_done = div_done;
      status.mac_done = mac_done;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = out_value_ff;
   assign rsp_clamped_key        = out_key_ff;
   assign rsp_low_index          = out_lo_ff;
   assign rsp_high_index         = out_hi_ff;
   assign rsp_high_weight        = out_wh_ff;
   assign rsp_range_status       = out_range_ff;

endmodule

// ----- src/tli_ctrl.sv -----
// ----------------------------------------------------------------------------
// tli_ctrl: sequencer for loads and queries
// steps a query through read, classify, scan and divide (in range only), blend and hand-off
// ----------------------------------------------------------------------------
module tli_ctrl
   import tli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_cmd == CMD_QUERY) begin
                  cmd.query_start = 1'b1;
                  state_in        = ST_FIRST;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_FIRST: begin
            cmd.rd_last = 1'b1;
            state_in    = ST_LAST;
         end
         ST_LAST: begin
            cmd.classify = 1'b1;
            state_in     = status.in_range ? ST_SCAN : ST_VAL_HI;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.found) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_VAL_HI;
            end
         end
         ST_VAL_HI: begin
            cmd.val_rd_hi = 1'b1;
            state_in      = ST_VAL_LO;
         end
         ST_VAL_LO: begin
            cmd.val_rd_lo = 1'b1;
            state_in      = ST_MAC_GO;
         end
         ST_MAC_GO: begin
            cmd.mac_start = 1'b1;
            state_in      = ST_MAC;
         end
         ST_MAC: begin
            if (status.mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/table_linear_interpolation.sv -----
// ----------------------------------------------------------------------------
// table_linear_interpolation: piecewise linear lookup over a loaded table
// loads write one key/value entry; queries return the interpolated value
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 beat contents
//  req_      in         req_valid / req_stall     cmd, entry index/key/value, query key
//  rsp_      out        rsp_valid / rsp_stall     value, clamped key, indexes, weight,
//                                                 range status
//  csr_      in/out     apb, pready tied high     entries_in_use at byte address 0
//
//  a load beat is written while the sequencer stays idle; a query inside the key
//  range runs the one-key-per-cycle scan of the key memory, the 16-step divider
//  and the 17-step shift-add blend; a clamped query skips the scan and the divider
//  reset clears the sequencer and result valid and sets entries_in_use to the
//  depth; table memories are not cleared
//  a result beat waits in the output register under rsp_stall while the next
//  request is taken; a later query holds in its last step until the slot frees
// ----------------------------------------------------------------------------
module table_linear_interpolation
   import tli_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF,
   parameter int IDX_W       = $clog2(TABLE_DEPTH),
   parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [IDX_W-1:0]      req_entry_index,
   input  logic [KEY_BITS-1:0]   req_entry_key,
   input  logic [VALUE_BITS-1:0] req_entry_value,
   input  logic [KEY_BITS-1:0]   req_query_key,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_interpolated_value,
   output logic [KEY_BITS-1:0]   rsp_clamped_key,
   output logic [IDX_W-1:0]      rsp_low_index,
   output logic [IDX_W-1:0]      rsp_high_index,
   output logic [WEIGHT_W-1:0]   rsp_high_weight,
   output logic [1:0]            rsp_range_status,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0] entries_ff, entries_in;
   logic             csr_sel_entries;
   dp_cmd_type       cmd;
   dp_status_type    status;

   // register decode, word index in paddr bit 2
   assign csr_pready      = 1'b1;
   assign csr_sel_entries = (csr_paddr[2] == REG_ENTRIES_IN_USE);

   always_comb begin
      entries_in = entries_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_entries) begin
         entries_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CNT_W'(TABLE_DEPTH);
      end else begin
         entries_ff <= entries_in;
      end
   end

   // register read back
   assign csr_prdata = csr_sel_entries ? {{(CSR_DATA_W - CNT_W){1'b0}}, entries_ff} : '0;

   // sequencer
   tli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // table and arithmetic
   tli_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .entries_in_use         (entries_ff),
      .entry_index            (req_entry_index),
      .entry_key              (req_entry_key),
      .entry_value            (req_entry_value),
      .query_key              (req_query_key),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_interpolated_value (rsp_interpolated_value),
      .rsp_clamped_key        (rsp_clamped_key),
      .rsp_low_index          (rsp_low_index),
      .rsp_high_index         (rsp_high_index),
      .rsp_high_weight        (rsp_high_weight),
      .rsp_range_status       (rsp_range_status)
   );

endmodule
